FILE: sv/multi_voice_sample_mixer_defines.svh
// Assertion macros shared by the mixer RTL.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_DEFINES_SVH

// The property must hold at every sampled edge.
`define MVSM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a sampled edge.
`define MVSM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: sv/mvsm_pkg.sv
`default_nettype none

package mvsm_pkg;

	localparam int VOICE_COUNT  = 8;
	// The sample store is addressed modulo its size, so the size must be a power of two.
	localparam int SAMPLE_WORDS = 65536;

	localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
	localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CNT_W   = $clog2(VOICE_COUNT + 1);
	localparam int SLOT_W  = 3;
	localparam int SLOT_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
	localparam int SPAN_W  = 17;
	localparam int WIDE_W  = (ADDR_W > SPAN_W) ? ADDR_W : SPAN_W;
	localparam int MASK_W  = 8;

	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_VOLUME = 3'd2;
	localparam logic [2:0] MODE_STOP   = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;

	typedef struct packed {
		logic [15:0]       base;
		logic [SPAN_W-1:0] span;
		logic [SPAN_W-1:0] pos;
		logic              rep;
		logic [15:0]       gain;
		logic              hold;
	} voice_rec_t;

	typedef struct packed {
		logic valid;
		logic play;
		logic first;
		logic last;
	} mix_ctl_t;

endpackage

`default_nettype wire

FILE: sv/mvsm_ram.sv
`default_nettype none

module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/mvsm_mix_dp.sv
`default_nettype none

module mvsm_mix_dp
	import mvsm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [15:0] smp,
	input  wire logic        [15:0] gain_s2,
	input  wire mix_ctl_t           ctl_s2,
	output logic signed      [15:0] acc,
	output logic                    done
);

	logic signed [32:0] prod_s3;
	logic signed [15:0] scaled_s4;
	mix_ctl_t           ctl_s3;
	mix_ctl_t           ctl_s4;
	logic signed [15:0] acc_q;
	logic               done_q;

	logic signed [16:0] gain_ext;
	logic signed [17:0] quot;
	logic signed [17:0] quot_tz;
	logic signed [15:0] acc_base;
	logic signed [16:0] acc_sum;

	assign gain_ext = {1'b0, gain_s2};

	// An arithmetic shift floors; a negative product with a nonzero remainder
	// moves up by one so the quotient truncates toward zero.
	assign quot    = prod_s3[32:15];
	assign quot_tz = quot + 18'(prod_s3[32] && (prod_s3[14:0] != 15'd0));

	assign acc_base = ctl_s4.first ? 16'sd0 : acc_q;
	assign acc_sum  = 17'(acc_base) + 17'(scaled_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done_q <= 1'b0;
			acc_q  <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done_q <= ctl_s4.valid && ctl_s4.last;
			if (ctl_s4.valid) begin
				if (!ctl_s4.play) begin
					acc_q <= acc_base;
				end else if (acc_sum > 17'sd32767) begin
					acc_q <= 16'sh7fff;
				end else if (acc_sum < -17'sd32768) begin
					acc_q <= -16'sh8000;
				end else begin
					acc_q <= acc_sum[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= smp * gain_ext;
		if (quot_tz > 18'sd32767) begin
			scaled_s4 <= 16'sh7fff;
		end else if (quot_tz < -18'sd32768) begin
			scaled_s4 <= -16'sh8000;
		end else begin
			scaled_s4 <= quot_tz[15:0];
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/multi_voice_sample_mixer.sv
// Channel  Direction  Handshake           Payload
// command  in         in_valid/in_stall   mode mem_address sample_value voice_slot
//                                         region_length repeat_flag gain hold
// result   out        out_valid/out_stall mixed_sample active_mask
//
// Write, start, stop and ignored commands complete when accepted; set volume reads
// and then writes back the voice record in the voice table, stalling input meanwhile.
// During a tick one voice record is read per cycle, then the sample read,
// multiply, scale and accumulate stages drain.
// The tick result waits in the output register; a following tick cannot finish
// until that result is taken. Reset leaves all voices inactive and the voice
// table reading as zero; the sample store needs no clearing.
`default_nettype none

`include "multi_voice_sample_mixer_defines.svh"

module multi_voice_sample_mixer
	import mvsm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         mode,
	input  wire logic [15:0]        mem_address,
	input  wire logic signed [15:0] sample_value,
	input  wire logic [SLOT_W-1:0]  voice_slot,
	input  wire logic [SPAN_W-1:0]  region_length,
	input  wire logic               repeat_flag,
	input  wire logic [15:0]        gain,
	input  wire logic               hold,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      mixed_sample,
	output logic [MASK_W-1:0]       active_mask
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOL_WR,
		ST_TICK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICE_COUNT - 1);

	state_t             state_q;
	logic [VOICE_W-1:0] iss_q;
	logic [VOICE_W-1:0] vol_slot_q;
	logic [15:0]        vol_gain_q;
	logic               vol_hold_q;
	logic               out_valid_q;
	logic signed [15:0] mixed_q;
	logic [MASK_W-1:0]  mask_q;

	logic [VOICE_COUNT-1:0] live_q;
	logic [VOICE_COUNT-1:0] vvalid_q;

	logic               vld_s1;
	logic [VOICE_W-1:0] v_s1;
	mix_ctl_t           ctl_s1;
	mix_ctl_t           ctl_s2;
	logic [15:0]        gain_s2;

	logic                  accept;
	logic [SLOT_CMP_W-1:0] slot_ext;
	logic                  slot_ok;
	logic [VOICE_W-1:0]    slot_idx;
	logic                  write_go;
	logic                  start_go;
	logic                  vol_go;
	logic                  stop_go;
	logic                  tick_go;

	logic                   vram_we;
	logic [VOICE_W-1:0]     vram_waddr;
	voice_rec_t             vram_wdata;
	logic                   vram_re;
	logic [VOICE_W-1:0]     vram_raddr;
	logic [$bits(voice_rec_t)-1:0] vram_rdata;

	voice_rec_t        rec_rd;
	logic              play_s1;
	logic [SPAN_W-1:0] pos_inc;
	logic              at_end;
	logic [SPAN_W-1:0] pos_next;
	logic [WIDE_W-1:0] rd_wide;
	logic [WIDE_W-1:0] wr_wide;

	logic signed [15:0] smp_rdata;
	logic signed [15:0] mix_acc;
	logic               mix_done;
	logic [MASK_W-1:0]  mask_now;
	logic               out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign slot_ext = SLOT_CMP_W'(voice_slot);
	assign slot_ok  = slot_ext < SLOT_CMP_W'(VOICE_COUNT);
	assign slot_idx = slot_ext[VOICE_W-1:0];

	assign write_go = accept && (mode == MODE_WRITE);
	assign start_go = accept && (mode == MODE_START) && slot_ok && (region_length != '0);
	assign vol_go   = accept && (mode == MODE_VOLUME) && slot_ok;
	assign stop_go  = accept && (mode == MODE_STOP) && slot_ok;
	assign tick_go  = accept && (mode == MODE_TICK);

	// A table entry never written reads as its reset value of zero.
	assign rec_rd = vld_s1 ? voice_rec_t'(vram_rdata) : '0;

	assign play_s1  = ctl_s1.valid && live_q[v_s1] && !rec_rd.hold;
	assign pos_inc  = rec_rd.pos + SPAN_W'(1);
	assign at_end   = pos_inc >= rec_rd.span;
	assign pos_next = (at_end && rec_rd.rep) ? '0 : pos_inc;

	assign rd_wide = WIDE_W'(rec_rd.base) + WIDE_W'(rec_rd.pos);
	assign wr_wide = WIDE_W'(mem_address);

	always_comb begin
		vram_we    = 1'b0;
		vram_waddr = slot_idx;
		vram_wdata = '0;
		vram_re    = 1'b0;
		vram_raddr = slot_idx;
		if (start_go) begin
			vram_we         = 1'b1;
			vram_wdata.base = mem_address;
			vram_wdata.span = region_length;
			vram_wdata.rep  = repeat_flag;
			vram_wdata.gain = gain;
		end
		if (vol_go) begin
			vram_re = 1'b1;
		end
		if (state_q == ST_VOL_WR) begin
			vram_we         = 1'b1;
			vram_waddr      = vol_slot_q;
			vram_wdata      = rec_rd;
			vram_wdata.gain = vol_gain_q;
			vram_wdata.hold = vol_hold_q;
		end
		if (state_q == ST_TICK) begin
			vram_re    = 1'b1;
			vram_raddr = iss_q;
		end
		// Write back the advanced cursor of the voice whose record was read in the previous cycle.
		if (play_s1) begin
			vram_we        = 1'b1;
			vram_waddr     = v_s1;
			vram_wdata     = rec_rd;
			vram_wdata.pos = pos_next;
		end
	end

	mvsm_ram #(
		.WIDTH($bits(voice_rec_t)),
		.DEPTH(VOICE_COUNT)
	) u_voice_ram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(vram_waddr),
		.wdata(vram_wdata),
		.re   (vram_re),
		.raddr(vram_raddr),
		.rdata(vram_rdata)
	);

	mvsm_ram #(
		.WIDTH(16),
		.DEPTH(SAMPLE_WORDS)
	) u_sample_ram (
		.clk  (clk),
		.we   (write_go),
		.waddr(wr_wide[ADDR_W-1:0]),
		.wdata(sample_value),
		.re   (play_s1),
		.raddr(rd_wide[ADDR_W-1:0]),
		.rdata(smp_rdata)
	);

	mvsm_mix_dp u_mix_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_rdata),
		.gain_s2(gain_s2),
		.ctl_s2 (ctl_s2),
		.acc    (mix_acc),
		.done   (mix_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			vvalid_q <= '0;
			vld_s1   <= 1'b0;
			ctl_s1   <= '0;
			ctl_s2   <= '0;
		end else begin
			if (vram_we) begin
				vvalid_q[vram_waddr] <= 1'b1;
			end
			if (vram_re) begin
				vld_s1 <= vvalid_q[vram_raddr];
			end
			if (start_go) begin
				live_q[slot_idx] <= 1'b1;
			end
			if (stop_go) begin
				live_q[slot_idx] <= 1'b0;
			end
			if (play_s1 && at_end && !rec_rd.rep) begin
				live_q[v_s1] <= 1'b0;
			end
			ctl_s1.valid <= (state_q == ST_TICK);
			ctl_s1.play  <= 1'b0;
			ctl_s1.first <= (iss_q == '0);
			ctl_s1.last  <= (iss_q == LAST_VOICE);
			ctl_s2       <= '{valid: ctl_s1.valid, play: play_s1, first: ctl_s1.first,
				last: ctl_s1.last};
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= iss_q;
		gain_s2 <= rec_rd.gain;
	end

	always_comb begin
		mask_now = '0;
		for (int v = 0; v < MASK_W; v++) begin
			if (v < VOICE_COUNT) begin
				mask_now[v] = live_q[VOICE_W'(v)];
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			vol_slot_q  <= '0;
			vol_gain_q  <= '0;
			vol_hold_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mixed_q     <= '0;
			mask_q      <= '0;
		end else begin
			// In the done state the register is either reloaded or held stalled.
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					iss_q <= '0;
					if (tick_go) begin
						state_q <= ST_TICK;
					end else if (vol_go) begin
						state_q    <= ST_VOL_WR;
						vol_slot_q <= slot_idx;
						vol_gain_q <= gain;
						vol_hold_q <= hold;
					end
				end
				ST_VOL_WR: begin
					state_q <= ST_IDLE;
				end
				ST_TICK: begin
					iss_q <= iss_q + VOICE_W'(1);
					if (iss_q == LAST_VOICE) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mix_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						mixed_q     <= mix_acc;
						mask_q      <= mask_now;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign mixed_sample = mixed_q;
	assign active_mask  = mask_q;

	`MVSM_NEVER(a_vram_clash, vram_we && vram_re && (vram_waddr == vram_raddr), "table clash")
	`MVSM_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "early result")
	`MVSM_ASSERT(a_s1_tick, ctl_s1.valid |-> (state_q == ST_TICK || state_q == ST_DRAIN), "stray stage")

endmodule

`default_nettype wire
